// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// field widths of a transaction
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int TAB_W  = 4;

	// APB port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// register index, taken from the word part of the byte address
	localparam logic REG_TAB_WIDTH = 1'b0;

	// character codes with a meaning of their own
	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [CHAR_W-1:0] ATTR_NORMAL = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0720;
	localparam logic [TAB_W-1:0]  TAB_RESET   = 4'd4;

	typedef enum logic [1:0] {
		REQ_PUT      = 2'd0,
		REQ_PUT_ECHO = 2'd1,
		REQ_CLEAR    = 2'd2,
		REQ_READ     = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAB,
		ST_SCROLL,
		ST_BLANK,
		ST_RESP
	} tcw_state_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [CHAR_W-1:0]  char_code;
		logic [IDX_W-1:0]   cell_index;
	} req_item_t;

	typedef struct packed {
		logic [POS_W-1:0]   cursor_pos;
		logic [CELL_W-1:0]  cell_value;
		logic               echo_valid;
		logic [CHAR_W-1:0]  echo_char;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels carrying requests into and results out of the console.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if
	import tcw_pkg::*;
();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tcw_rsp_if
	import tcw_pkg::*;
();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console of ROWS x COLUMNS cells kept in one cell RAM. Puts characters
// at the cursor, handles newline, backspace and tab, scrolls at the bottom,
// clears the screen and reads back cells. One result per request.
// ----------------------------------------------------------------------------
// Tab: one cell write per space. Scroll copies the rows up through the single
// RAM port pair, then blanks the bottom row; clear blanks every cell.
// After reset a clearing pass blanks the RAM; no request is taken until it
// ends. Cursor resets to 0, tab_width to 4.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tcw_req_if.sink                     req,
	tcw_rsp_if.source                   rsp,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic      [APB_DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_CELLS = AW'(CELLS - COLUMNS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

	tcw_state_t state_q, state_d;

	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [TAB_W-1:0]  tab_q;
	logic [TAB_W-1:0]  tab_left_q, tab_left_d;
	logic [AW-1:0]     sc_q, sc_d;
	logic              init_q, init_d;
	logic              echo_q, echo_d;
	logic [CHAR_W-1:0] ch_q, ch_d;
	logic              rd_hit_q, rd_hit_d;
	logic              vld_s1, vld_d;
	logic [AW-1:0]     wa_s1, wa_d;
	logic              out_valid_q;
	rsp_item_t         out_q;
	logic              load_out;

	// RAM ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// cursor arithmetic
	logic [AW-1:0]     cur_lin;
	logic [CW:0]       col_inc;
	logic              col_wrap;
	logic              row_last;
	logic [CW-1:0]     adv_col;
	logic [RW-1:0]     adv_row;
	logic              adv_scroll;
	logic [RW-1:0]     nl_row;
	logic              idx_ok;
	logic              tab_wr;

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// linear cursor address and the effect of advancing one column
	assign cur_lin  = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign col_inc  = {1'b0, col_q} + (CW+1)'(1);
	assign col_wrap = (32'(col_inc) == COLUMNS);
	assign row_last = (row_q == LAST_ROW);
	assign nl_row   = row_last ? row_q : row_q + RW'(1);
	assign idx_ok   = (32'(req.data.cell_index) < CELLS);

	always_comb begin
		adv_col    = col_inc[CW-1:0];
		adv_row    = row_q;
		adv_scroll = 1'b0;
		if (col_wrap) begin
			adv_col    = '0;
			adv_row    = nl_row;
			adv_scroll = row_last;
		end
	end

	// APB register
	assign pready = 1'b1;
	assign tab_wr = psel && penable && pwrite && (paddr[2] == REG_TAB_WIDTH);
	assign prdata = (paddr[2] == REG_TAB_WIDTH) ? APB_DATA_W'(tab_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= TAB_RESET;
		end else if (tab_wr) begin
			tab_q <= pwdata[TAB_W-1:0];
		end
	end

	assign req.ready = (state_q == ST_IDLE);

	// next state, cursor update and RAM access
	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		tab_left_d = tab_left_q;
		sc_d       = sc_q;
		init_d     = init_q;
		echo_d     = echo_q;
		ch_d       = ch_q;
		rd_hit_d   = rd_hit_q;
		vld_d      = 1'b0;
		wa_d       = wa_s1;
		load_out   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cur_lin;
		ram_wdata  = BLANK_CELL;
		ram_re     = 1'b0;
		ram_raddr  = AW'(32'(sc_q) + COLUMNS);

		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sc_q;
				if (sc_q == LAST_CELL) begin
					sc_d    = '0;
					row_d   = '0;
					col_d   = '0;
					init_d  = 1'b0;
					state_d = init_q ? ST_IDLE : ST_RESP;
				end else begin
					sc_d = sc_q + AW'(1);
				end
			end

			ST_IDLE: begin
				if (req.valid) begin
					ch_d       = req.data.char_code;
					echo_d     = 1'b0;
					rd_hit_d   = 1'b0;
					tab_left_d = '0;
					sc_d       = '0;
					state_d    = ST_RESP;
					case (req.data.req_type) inside
						REQ_PUT, REQ_PUT_ECHO: begin
							case (req.data.char_code)
								CHAR_NL: begin
									col_d  = '0;
									row_d  = nl_row;
									echo_d = (req.data.req_type == REQ_PUT_ECHO);
									if (row_last) begin
										state_d = ST_SCROLL;
									end
								end
								CHAR_BS: begin
									if (col_q > CW'(2)) begin
										col_d     = col_q - CW'(1);
										ram_we    = 1'b1;
										ram_waddr = cur_lin - AW'(1);
										echo_d    = (req.data.req_type == REQ_PUT_ECHO);
									end
								end
								CHAR_TAB: begin
									if (tab_q != '0) begin
										tab_left_d = tab_q;
										state_d    = ST_TAB;
									end
								end
								default: begin
									ram_we    = 1'b1;
									ram_wdata = {ATTR_NORMAL, req.data.char_code};
									col_d     = adv_col;
									row_d     = adv_row;
									echo_d    = (req.data.req_type == REQ_PUT_ECHO);
									if (adv_scroll) begin
										state_d = ST_SCROLL;
									end
								end
							endcase
						end
						REQ_CLEAR: begin
							state_d = ST_CLEAR;
						end
						default: begin
							// cell read; out-of-range index reads zero
							if (idx_ok) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(req.data.cell_index);
								rd_hit_d  = 1'b1;
							end
						end
					endcase
				end
			end

			ST_TAB: begin
				ram_we     = 1'b1;
				ram_wdata  = {ATTR_NORMAL, CHAR_SPACE};
				col_d      = adv_col;
				row_d      = adv_row;
				tab_left_d = tab_left_q - TAB_W'(1);
				if (adv_scroll) begin
					state_d = ST_SCROLL;
				end else if (tab_left_q == TAB_W'(1)) begin
					state_d = ST_RESP;
				end
			end

			ST_SCROLL: begin
				// read one row ahead, write back the cell read last cycle
				ram_we    = vld_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
				if (sc_q < COPY_CELLS) begin
					ram_re = 1'b1;
					vld_d  = 1'b1;
					wa_d   = sc_q;
					sc_d   = sc_q + AW'(1);
				end else begin
					state_d = ST_BLANK;
				end
			end

			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = sc_q;
				if (sc_q == LAST_CELL) begin
					sc_d    = '0;
					state_d = (tab_left_q != '0) ? ST_TAB : ST_RESP;
				end else begin
					sc_d = sc_q + AW'(1);
				end
			end

			ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			tab_left_q <= '0;
			sc_q       <= '0;
			init_q     <= 1'b1;
			echo_q     <= 1'b0;
			rd_hit_q   <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			row_q      <= row_d;
			col_q      <= col_d;
			tab_left_q <= tab_left_d;
			sc_q       <= sc_d;
			init_q     <= init_d;
			echo_q     <= echo_d;
			rd_hit_q   <= rd_hit_d;
			vld_s1     <= vld_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ch_q  <= ch_d;
		wa_s1 <= wa_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.cursor_pos <= POS_W'(cur_lin);
			out_q.cell_value <= rd_hit_q ? ram_rdata : '0;
			out_q.echo_valid <= echo_q;
			out_q.echo_char  <= echo_q ? ch_q : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

`default_nettype wire
